@@ sv/lspg_pkg.sv @@
`timescale 1ns / 1ps

package lspg_pkg;

    // pattern codes, same encoding on input and output
    localparam logic [2:0] PAT_OFF     = 3'd0;
    localparam logic [2:0] PAT_SOLID   = 3'd1;
    localparam logic [2:0] PAT_BLINK   = 3'd2;
    localparam logic [2:0] PAT_BREATH  = 3'd3;
    localparam logic [2:0] PAT_PULSE   = 3'd4;
    localparam logic [2:0] PAT_SOS     = 3'd5;
    localparam logic [2:0] PAT_FLASH   = 3'd6;
    localparam logic [2:0] PAT_INVALID = 3'd7;

    // item kinds
    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_SELECT = 1'b1;

    // configuration register indexes
    localparam logic [3:0] CFG_BLINK_ON   = 4'd0;
    localparam logic [3:0] CFG_BLINK_OFF  = 4'd1;
    localparam logic [3:0] CFG_PULSE_HIGH = 4'd2;
    localparam logic [3:0] CFG_PULSE_LOW  = 4'd3;
    localparam logic [3:0] CFG_SOS_SHORT  = 4'd4;
    localparam logic [3:0] CFG_SOS_LONG   = 4'd5;
    localparam logic [3:0] CFG_SOS_GAP    = 4'd6;
    localparam logic [3:0] CFG_FLASH_ON   = 4'd7;

    // fixed timings in ms
    localparam logic [11:0] BREATH_RAMP_MS  = 12'd1500;
    localparam logic [11:0] BREATH_PAUSE_MS = 12'd200;
    localparam logic [11:0] FLASH_OFF_MS    = 12'd100;
    localparam logic [11:0] SOS_PAUSE_MS    = 12'd600;

    // phase bookkeeping
    localparam int          PHASE_W         = 5;
    localparam int          ACC_W           = 11;
    localparam logic [4:0]  SOS_GROUP       = 5'd3;
    localparam logic [4:0]  SOS_PAUSE_PHASE = 5'd18;
    localparam logic [4:0]  BREATH_LAST     = 5'd2;
    localparam logic [4:0]  PAIR_LAST       = 5'd1;

    // opening level of a phase, turned into a duty by the engine
    typedef enum logic [1:0] {
        LVL_ZERO,
        LVL_FULL,
        LVL_EIGHTH
    } t_level;

    typedef struct packed {
        logic       action;
        logic [2:0] pattern_code;
    } t_in_item;

    typedef struct packed {
        logic [9:0] duty_level;
        logic [2:0] active_pattern;
        logic       status;
    } t_out_item;

    typedef struct packed {
        logic [11:0] blink_on_ms;
        logic [11:0] blink_off_ms;
        logic [11:0] pulse_high_ms;
        logic [11:0] pulse_low_ms;
        logic [11:0] sos_short_ms;
        logic [11:0] sos_long_ms;
        logic [11:0] sos_gap_ms;
        logic [11:0] flash_on_ms;
    } t_cfg;

endpackage

@@ sv/lspg_engine.sv @@
`timescale 1ns / 1ps

module lspg_engine import lspg_pkg::*; #(
    parameter int DUTY_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_step,
    input  t_in_item             i_item,
    output logic [DUTY_BITS-1:0] o_next_duty,
    output logic [2:0]           o_next_pattern,
    output logic                 o_status
);

    localparam logic [DUTY_BITS-1:0] FULL_DUTY   = {DUTY_BITS{1'b1}};
    localparam logic [DUTY_BITS-1:0] EIGHTH_DUTY = FULL_DUTY >> 3;
    localparam int                   FULL_INT    = (1 << DUTY_BITS) - 1;
    // per tick the ramp adds (or, on the way down, subtracts) M/1500 plus a carry from the remainder
    localparam int                   RAMP_Q      = FULL_INT / 1500;
    localparam int                   RAMP_R      = FULL_INT % 1500;

    logic [2:0]           r_pattern, n_pattern;
    logic [PHASE_W-1:0]   r_phase, n_phase;
    logic [11:0]          r_elapsed, n_elapsed;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [DUTY_BITS-1:0] r_duty, n_duty;
    logic                 n_status;

    logic [11:0]          acc_sum;
    logic                 ramp_carry;
    logic [DUTY_BITS-1:0] ramp_q;
    logic [DUTY_BITS:0]   duty_up;
    logic [12:0]          elapsed_inc;
    logic [11:0]          phase_len;
    logic [PHASE_W-1:0]   next_phase;

    // length of a phase in ms
    function automatic logic [11:0] phase_length(
        input logic [2:0] p, input logic [PHASE_W-1:0] ph, input t_cfg cfg
    );
        logic [11:0] len;
        len = 12'd0;
        case (p)
            PAT_BLINK:  len = (ph == '0) ? cfg.blink_on_ms : cfg.blink_off_ms;
            PAT_PULSE:  len = (ph == '0) ? cfg.pulse_high_ms : cfg.pulse_low_ms;
            PAT_BREATH: len = (ph < BREATH_LAST) ? BREATH_RAMP_MS : BREATH_PAUSE_MS;
            PAT_SOS: begin
                if (ph >= SOS_PAUSE_PHASE) begin
                    len = SOS_PAUSE_MS;
                end else if (ph[0]) begin
                    len = cfg.sos_gap_ms;
                end else if ((ph >> 1) >= SOS_GROUP && (ph >> 1) < (SOS_GROUP << 1)) begin
                    len = cfg.sos_long_ms;
                end else begin
                    len = cfg.sos_short_ms;
                end
            end
            PAT_FLASH:  len = (ph == '0) ? cfg.flash_on_ms : FLASH_OFF_MS;
            default:    len = 12'd0;
        endcase
        return len;
    endfunction

    // index of the last phase before the pattern wraps
    function automatic logic [PHASE_W-1:0] last_phase(input logic [2:0] p);
        logic [PHASE_W-1:0] lp;
        case (p)
            PAT_BREATH: lp = BREATH_LAST;
            PAT_SOS:    lp = SOS_PAUSE_PHASE;
            default:    lp = PAIR_LAST;
        endcase
        return lp;
    endfunction

    // level a phase opens with
    function automatic t_level opening_level(
        input logic [2:0] p, input logic [PHASE_W-1:0] ph
    );
        t_level lv;
        lv = LVL_ZERO;
        case (p)
            PAT_SOLID:  lv = LVL_FULL;
            PAT_BLINK:  lv = (ph == '0) ? LVL_FULL : LVL_ZERO;
            PAT_BREATH: lv = (ph == PHASE_W'(1)) ? LVL_FULL : LVL_ZERO;
            PAT_PULSE:  lv = (ph == '0) ? LVL_FULL : LVL_EIGHTH;
            PAT_SOS:    lv = (ph < SOS_PAUSE_PHASE && !ph[0]) ? LVL_FULL : LVL_ZERO;
            PAT_FLASH:  lv = (ph == '0) ? LVL_FULL : LVL_ZERO;
            default:    lv = LVL_ZERO;
        endcase
        return lv;
    endfunction

    function automatic logic [DUTY_BITS-1:0] level_duty(input t_level lv);
        logic [DUTY_BITS-1:0] d;
        case (lv)
            LVL_FULL:   d = FULL_DUTY;
            LVL_EIGHTH: d = EIGHTH_DUTY;
            default:    d = '0;
        endcase
        return d;
    endfunction

    // ramp arithmetic for breathing, remainder stays below 1500
    assign acc_sum    = 12'(r_acc) + 12'(RAMP_R);
    assign ramp_carry = (acc_sum >= BREATH_RAMP_MS);
    assign ramp_q     = DUTY_BITS'(RAMP_Q) + DUTY_BITS'(ramp_carry);
    assign duty_up    = {1'b0, r_duty} + {1'b0, ramp_q};

    // phase timing
    assign elapsed_inc = {1'b0, r_elapsed} + 13'd1;
    assign phase_len   = phase_length(r_pattern, r_phase, i_cfg);
    assign next_phase  = (r_phase == last_phase(r_pattern)) ? '0 : r_phase + PHASE_W'(1);

    // next state for a select or a tick
    always_comb begin
        n_pattern = r_pattern;
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_acc     = r_acc;
        n_duty    = r_duty;
        n_status  = 1'b0;
        if (i_item.action == ACT_SELECT) begin
            if (i_item.pattern_code == PAT_INVALID) begin
                n_status = 1'b1;
            end else if (i_item.pattern_code != r_pattern) begin
                n_pattern = i_item.pattern_code;
                n_phase   = '0;
                n_elapsed = '0;
                n_acc     = '0;
                n_duty    = level_duty(opening_level(i_item.pattern_code, '0));
            end
        end else if (r_pattern != PAT_OFF && r_pattern != PAT_SOLID
                     && r_pattern != PAT_INVALID) begin
            if (r_pattern == PAT_BREATH && r_phase < BREATH_LAST) begin
                n_acc = ramp_carry ? ACC_W'(acc_sum - BREATH_RAMP_MS) : acc_sum[ACC_W-1:0];
                if (r_phase == '0) begin
                    n_duty = duty_up[DUTY_BITS] ? FULL_DUTY : duty_up[DUTY_BITS-1:0];
                end else begin
                    n_duty = (r_duty > ramp_q) ? r_duty - ramp_q : '0;
                end
            end
            if (elapsed_inc >= {1'b0, phase_len}) begin
                n_elapsed = '0;
                n_acc     = '0;
                if (r_pattern == PAT_FLASH && r_phase >= PAIR_LAST) begin
                    n_pattern = PAT_OFF;
                    n_phase   = '0;
                    n_duty    = '0;
                end else begin
                    n_phase = next_phase;
                    n_duty  = level_duty(opening_level(r_pattern, next_phase));
                end
            end else begin
                n_elapsed = elapsed_inc[11:0];
            end
        end
    end

    // state registers, advance once per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= PAT_OFF;
            r_phase   <= '0;
            r_elapsed <= '0;
            r_acc     <= '0;
            r_duty    <= '0;
        end else if (i_step) begin
            r_pattern <= n_pattern;
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_acc     <= n_acc;
            r_duty    <= n_duty;
        end
    end

    assign o_next_duty    = n_duty;
    assign o_next_pattern = n_pattern;
    assign o_status       = n_status;

endmodule

@@ sv/led_status_pattern_generator.sv @@
`timescale 1ns / 1ps

// channel   direction  handshake                   payload
// in        input      i_in_valid / o_in_ready     i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_ready   o_out_data (t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// one item per cycle: each transfer updates the pattern state in the same
// cycle and its result appears in the output register on the next cycle
// the output register frees itself in the cycle it is taken, so input keeps
// flowing while results are consumed; input stalls only while it stays full
// reset clears the pattern to off and loads the default timings

module led_status_pattern_generator import lspg_pkg::*; #(
    parameter int DUTY_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    t_cfg                   r_cfg;
    logic                   r_out_valid;
    t_out_item              r_out_data;
    logic                   in_xfer;
    logic [DUTY_BITS-1:0]   next_duty;
    logic [2:0]             next_pattern;
    logic                   next_status;
    logic [DUTY_BITS+9:0]   duty_wide;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_xfer     = i_in_valid && o_in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blink_on_ms   <= 12'd100;
            r_cfg.blink_off_ms  <= 12'd100;
            r_cfg.pulse_high_ms <= 12'd500;
            r_cfg.pulse_low_ms  <= 12'd500;
            r_cfg.sos_short_ms  <= 12'd120;
            r_cfg.sos_long_ms   <= 12'd360;
            r_cfg.sos_gap_ms    <= 12'd160;
            r_cfg.flash_on_ms   <= 12'd120;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BLINK_ON:   r_cfg.blink_on_ms   <= i_cfg_data;
                CFG_BLINK_OFF:  r_cfg.blink_off_ms  <= i_cfg_data;
                CFG_PULSE_HIGH: r_cfg.pulse_high_ms <= i_cfg_data;
                CFG_PULSE_LOW:  r_cfg.pulse_low_ms  <= i_cfg_data;
                CFG_SOS_SHORT:  r_cfg.sos_short_ms  <= i_cfg_data;
                CFG_SOS_LONG:   r_cfg.sos_long_ms   <= i_cfg_data;
                CFG_SOS_GAP:    r_cfg.sos_gap_ms    <= i_cfg_data;
                CFG_FLASH_ON:   r_cfg.flash_on_ms   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lspg_engine #(
        .DUTY_BITS (DUTY_BITS)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_step         (in_xfer),
        .i_item         (i_in_data),
        .o_next_duty    (next_duty),
        .o_next_pattern (next_pattern),
        .o_status       (next_status)
    );

    // low ten bits of the duty, zero filled for narrow duties
    assign duty_wide = (DUTY_BITS + 10)'(next_duty);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data.duty_level     <= duty_wide[9:0];
            r_out_data.active_pattern <= next_pattern;
            r_out_data.status         <= next_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
